[rtl/hidp_pkg.sv]
package hidp_pkg;

    localparam int USAGE_DEPTH_DEF = 16;
    localparam int MAX_FIELDS_DEF  = 64;

    // Result kinds
    localparam logic [1:0] KIND_IN   = 2'd0;
    localparam logic [1:0] KIND_OUT  = 2'd1;
    localparam logic [1:0] KIND_APP  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LONG  = 2'd1;
    localparam logic [1:0] ERR_CLAMP = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    // Item tags (header with size bits masked)
    localparam logic [7:0] TAG_MASK   = 8'hFC;
    localparam logic [7:0] TAG_INPUT  = 8'h80;
    localparam logic [7:0] TAG_OUTPUT = 8'h90;
    localparam logic [7:0] TAG_COLL   = 8'hA0;
    localparam logic [7:0] TAG_RSIZE  = 8'h74;
    localparam logic [7:0] TAG_RCOUNT = 8'h94;
    localparam logic [7:0] TAG_PAGE   = 8'h04;
    localparam logic [7:0] TAG_USAGE  = 8'h08;
    localparam logic [7:0] TAG_UMIN   = 8'h18;
    localparam logic [7:0] HDR_LONG   = 8'hFE;
    localparam logic [1:0] SIZE_MASK  = 2'h3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIELD,
        ST_SHIFT,
        ST_EMIT
    } t_state;

    // Number of data bytes for a header size code
    function automatic logic [2:0] size_of_code(input logic [7:0] h);
        logic [1:0] c;
        c = h[1:0] & SIZE_MASK;
        return (c == 2'd3) ? 3'd4 : {1'b0, c};
    endfunction

endpackage

[rtl/hid_report_descriptor_parser_unit.sv]
// A byte that completes no item is taken in ST_IDLE; a completing byte then runs in ST_EXEC,
// and an application collection holds its record until the type is read from the list.
// Input/Output items: each element runs in ST_FIELD, after a registered read of the usage list
// head where one is used; ST_SHIFT moves the list down when more than one usage remains.
// Results: at most one per cycle, while i_ready holds; no byte is taken until an item is done.
// Reset: i_rst_n, synchronous active low, clears all state; i_first clears globals, usages and offsets.
module hid_report_descriptor_parser_unit #(
    parameter int USAGE_DEPTH = hidp_pkg::USAGE_DEPTH_DEF,
    parameter int MAX_FIELDS  = hidp_pkg::MAX_FIELDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_usage,
    output logic [15:0] o_bit_offset,
    output logic [7:0]  o_bit_size,
    output logic        o_is_index,
    output logic        o_is_relative,
    output logic [1:0]  o_error_code,
    output logic        o_last
);
    import hidp_pkg::*;

    localparam int AW = $clog2(USAGE_DEPTH);
    localparam int CW = $clog2(USAGE_DEPTH + 1);
    localparam int FW = $clog2(MAX_FIELDS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(USAGE_DEPTH);
    localparam logic [FW-1:0] MAXF_C  = FW'(MAX_FIELDS);

    t_state r_state, n_state;

    logic [7:0]    r_hdr;
    logic [2:0]    r_left;
    logic [31:0]   r_data;
    logic [7:0]    r_page;
    logic [7:0]    r_rsize;
    logic [31:0]   r_rcount;
    logic [CW-1:0] r_ucnt;
    logic [31:0]   r_umin;
    logic [15:0]   r_in_off;
    logic [15:0]   r_out_off;
    logic [FW-1:0] r_fcnt;
    logic [AW-1:0] r_sidx;
    logic          r_rd_pend;

    // Output register
    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [31:0] r_usage;
    logic [15:0] r_off;
    logic [7:0]  r_size;
    logic        r_idx;
    logic        r_rel;
    logic [1:0]  r_err;
    logic        r_last;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    hidp_usage_mem #(.USAGE_DEPTH(USAGE_DEPTH), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    logic [7:0]  tag;
    logic        is_io, is_in_item, cst, var_f, rel_f, clamped;
    logic [FW-1:0] cnt_eff;
    logic [15:0] cur_off;
    logic        app_pend;
    logic        out_free;

    assign tag        = r_hdr & TAG_MASK;
    assign is_in_item = (tag == TAG_INPUT);
    assign is_io      = is_in_item || (tag == TAG_OUTPUT);
    assign cst        = r_data[0];
    assign var_f      = r_data[1];
    assign rel_f      = r_data[2];
    assign clamped    = (r_rcount > 32'(MAX_FIELDS));
    assign cnt_eff    = clamped ? MAXF_C : FW'(r_rcount);
    assign cur_off    = is_in_item ? r_in_off : r_out_off;
    // Collection type still on its way from the memory
    assign app_pend   = r_rd_pend && (r_kind == KIND_APP) && (r_state == ST_IDLE);
    assign out_free   = !r_ovalid || (o_valid && i_ready);

    assign o_ready = (r_state == ST_IDLE) && out_free;

    logic acc;
    assign acc = i_valid && o_ready;

    // Field phase: does the current element need the list head?
    logic need_head;
    assign need_head = !cst && var_f && (r_ucnt != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if ((i_first || r_left == 3'd0) && i_data_byte == HDR_LONG) begin
                        n_state = ST_IDLE;
                    end else if ((i_first || r_left == 3'd0)
                                 ? (size_of_code(i_data_byte) == 3'd0)
                                 : (r_left == 3'd1)) begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (is_io) begin
                    n_state = (cnt_eff == '0) ? ST_IDLE : ST_FIELD;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FIELD: begin
                if (need_head && !r_rd_pend) begin
                    n_state = ST_FIELD;
                end else if (cst || out_free) begin
                    n_state = (r_fcnt == FW'(1)) ? ST_IDLE
                            : (need_head && r_ucnt > CW'(1)) ? ST_SHIFT : ST_FIELD;
                end
            end
            ST_SHIFT: begin
                if (r_rd_pend && r_sidx == AW'(r_ucnt - CW'(2))) begin
                    n_state = ST_FIELD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ucnt[AW-1:0];
        mem_wdata = {8'h00, r_page, 16'h0000} | r_data;
        mem_raddr = '0;
        if (r_state == ST_EXEC && tag == TAG_USAGE && r_ucnt < DEPTH_C) begin
            mem_we = 1'b1;
        end
        if (r_state == ST_EXEC && tag == TAG_COLL) begin
            mem_raddr = AW'(r_ucnt - CW'(1));
        end
        if (r_state == ST_SHIFT) begin
            mem_raddr = r_rd_pend ? r_sidx + AW'(2) : r_sidx + AW'(1);
            mem_we    = r_rd_pend;
            mem_waddr = r_sidx;
            mem_wdata = mem_rdata;
        end
    end

    logic [CW-1:0] n_ucnt_coll;
    assign n_ucnt_coll = (r_ucnt != '0) ? r_ucnt - CW'(1) : r_ucnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_hdr     <= '0;
            r_left    <= '0;
            r_data    <= '0;
            r_page    <= '0;
            r_rsize   <= '0;
            r_rcount  <= '0;
            r_ucnt    <= '0;
            r_umin    <= '0;
            r_in_off  <= '0;
            r_out_off <= '0;
            r_fcnt    <= '0;
            r_sidx    <= '0;
            r_rd_pend <= 1'b0;
            r_ovalid  <= 1'b0;
            r_kind    <= '0;
            r_usage   <= '0;
            r_off     <= '0;
            r_size    <= '0;
            r_idx     <= 1'b0;
            r_rel     <= 1'b0;
            r_err     <= '0;
            r_last    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (i_first || r_left == 3'd0) begin
                            if (i_first) begin
                                r_page    <= '0;
                                r_rsize   <= '0;
                                r_rcount  <= '0;
                                r_ucnt    <= '0;
                                r_umin    <= '0;
                                r_in_off  <= '0;
                                r_out_off <= '0;
                            end
                            r_hdr  <= i_data_byte;
                            r_data <= '0;
                            r_left <= size_of_code(i_data_byte);
                            if (i_data_byte == HDR_LONG) begin
                                r_ovalid <= 1'b1;
                                r_kind   <= KIND_ERR;
                                r_usage  <= '0;
                                r_off    <= '0;
                                r_size   <= '0;
                                r_idx    <= 1'b0;
                                r_rel    <= 1'b0;
                                r_err    <= ERR_LONG;
                                r_last   <= 1'b1;
                            end
                        end else begin
                            unique case (size_of_code(r_hdr) - r_left)
                                3'd0:    r_data[7:0]   <= i_data_byte;
                                3'd1:    r_data[15:8]  <= i_data_byte;
                                3'd2:    r_data[23:16] <= i_data_byte;
                                default: r_data[31:24] <= i_data_byte;
                            endcase
                            r_left <= r_left - 3'd1;
                        end
                    end
                end
                ST_EXEC: begin
                    r_fcnt    <= cnt_eff;
                    r_rd_pend <= 1'b0;
                    if (is_io) begin
                        if (cnt_eff == '0) r_ucnt <= '0;
                    end else if (out_free) begin
                        if (tag == TAG_COLL) begin
                            r_ucnt <= n_ucnt_coll;
                            if (r_data == 32'd1) begin
                                r_ovalid <= 1'b1;
                                r_kind   <= KIND_APP;
                                r_usage  <= '0;
                                r_rd_pend <= (r_ucnt != '0);
                                r_off    <= '0;
                                r_size   <= '0;
                                r_idx    <= 1'b0;
                                r_rel    <= 1'b0;
                                r_err    <= ERR_NONE;
                                r_last   <= 1'b1;
                            end
                        end else if (tag == TAG_PAGE) begin
                            r_page <= r_data[7:0];
                        end else if (tag == TAG_RSIZE) begin
                            r_rsize <= r_data[7:0];
                        end else if (tag == TAG_RCOUNT) begin
                            r_rcount <= r_data;
                        end else if (tag == TAG_USAGE) begin
                            if (r_ucnt < DEPTH_C) begin
                                r_ucnt <= r_ucnt + CW'(1);
                            end else begin
                                r_ovalid <= 1'b1;
                                r_kind   <= KIND_ERR;
                                r_usage  <= '0;
                                r_off    <= '0;
                                r_size   <= '0;
                                r_idx    <= 1'b0;
                                r_rel    <= 1'b0;
                                r_err    <= ERR_FULL;
                                r_last   <= 1'b1;
                            end
                        end else if (tag == TAG_UMIN) begin
                            r_ucnt <= '0;
                            r_umin <= {8'h00, r_page, 16'h0000} | r_data;
                        end
                    end
                end
                ST_FIELD: begin
                    if (need_head && !r_rd_pend) begin
                        r_rd_pend <= 1'b1;
                    end else if (cst || out_free) begin
                        r_rd_pend <= 1'b0;
                        r_fcnt    <= r_fcnt - FW'(1);
                        if (is_in_item) r_in_off  <= r_in_off + 16'(r_rsize);
                        else            r_out_off <= r_out_off + 16'(r_rsize);
                        if (!cst) begin
                            r_ovalid <= 1'b1;
                            r_kind   <= is_in_item ? KIND_IN : KIND_OUT;
                            r_usage  <= need_head ? mem_rdata : r_umin;
                            r_off    <= cur_off;
                            r_size   <= r_rsize;
                            r_idx    <= !var_f;
                            r_rel    <= rel_f;
                            r_err    <= clamped ? ERR_CLAMP : ERR_NONE;
                            r_last   <= (r_fcnt == FW'(1));
                        end
                        if (!cst && var_f && r_ucnt == '0) begin
                            r_umin <= r_umin + 32'd1;
                        end
                        r_sidx <= '0;
                        // The list is emptied after the last element, so no shift then
                        if (r_fcnt == FW'(1)) begin
                            r_ucnt <= '0;
                        end
                    end
                end
                ST_SHIFT: begin
                    // Move list[i+1] -> list[i]; each write lands in the cycle after its registered read
                    r_rd_pend <= 1'b1;
                    if (r_rd_pend) r_sidx <= r_sidx + AW'(1);
                    if (r_rd_pend && r_sidx == AW'(r_ucnt - CW'(2))) begin
                        r_rd_pend <= 1'b0;
                        r_ucnt    <= r_ucnt - CW'(1);
                    end
                end
                default: ;
            endcase
            // Collection type arrives from the registered read of the list
            if (app_pend) begin
                r_usage   <= mem_rdata;
                r_rd_pend <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid && !app_pend;
    assign o_kind        = r_kind;
    assign o_usage       = r_usage;
    assign o_bit_offset  = r_off;
    assign o_bit_size    = r_size;
    assign o_is_index    = r_idx;
    assign o_is_relative = r_rel;
    assign o_error_code  = r_err;
    assign o_last        = r_last;

    // Not ready while an item runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("ready during item execution");

    // Usage count never exceeds the list depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= DEPTH_C)
        else $error("usage count overflow");

    // Error records carry zero usage and a nonzero error code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERR) |-> (o_usage == '0 && o_error_code != ERR_NONE))
        else $error("malformed error record");

endmodule

[rtl/hidp_usage_mem.sv]
module hidp_usage_mem #(
    parameter int USAGE_DEPTH = hidp_pkg::USAGE_DEPTH_DEF,
    parameter int AW = $clog2(USAGE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    import hidp_pkg::*;

    logic [31:0] r_mem [USAGE_DEPTH];
    logic [31:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
